>>> src/nrr_pkg.sv
`timescale 1ns / 1ps
package nrr_pkg;
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_ADD = 2'd1;
  localparam logic [1:0] OP_DUMP = 2'd2;

  localparam logic [2:0] ST_INSERTED = 3'd0;
  localparam logic [2:0] ST_DUPLICATE = 3'd1;
  localparam logic [2:0] ST_DROPPED = 3'd2;
  localparam logic [2:0] ST_DUMP_ENTRY = 3'd3;
  localparam logic [2:0] ST_CLEARED = 3'd4;
  localparam logic [2:0] ST_DUMP_EMPTY = 3'd5;

  localparam logic [7:0] COUNT_MAX = 8'd255;

  typedef struct packed {
    logic [47:0] gateway_id;
    logic [7:0] modem_id;
    logic [7:0] rssi_upstream;
    logic [7:0] rssi_downstream;
    logic [31:0] pong_epoch;
    logic signed [15:0] freq_offset;
    logic [31:0] recv_time_us;
  } entry_t;

  typedef struct packed {
    logic [1:0] operation;
    entry_t e;
  } in_word_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] reply_count;
    logic [2:0] rank;
    entry_t e;
    logic last;
  } out_word_t;
endpackage

>>> src/nrr_if.sv
`timescale 1ns / 1ps
interface nrr_in_if;
  logic valid;
  logic ready;
  nrr_pkg::in_word_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface nrr_out_if;
  logic valid;
  logic ready;
  nrr_pkg::out_word_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

>>> src/nrr_mem.sv
`timescale 1ns / 1ps
module nrr_mem #(
  parameter int DEPTH = 8,
  parameter int AW = 3
) (
  input  logic clk,
  input  logic we,
  input  logic [AW-1:0] waddr,
  input  nrr_pkg::entry_t wdata,
  input  logic [AW-1:0] raddr,
  output nrr_pkg::entry_t rdata
);
  nrr_pkg::entry_t mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> src/top_n_rssi_reply_ranker.sv
`timescale 1ns / 1ps
// Keeps the LIST_DEPTH best replies, slot 0 worst, in one slot memory with a
// registered read. An add scans all slots for a duplicate key and the insert
// position; unless the reply is a duplicate or worse than slot 0, it then moves
// each lower slot down, each by a read and a write, and writes the new reply. A
// clear writes every slot, one per cycle. A dump reads each slot in turn and
// sends one word per slot once the previous word has been accepted. A new word
// is taken only after the result of the previous one has been accepted. After
// reset a clearing pass over every slot runs before the first word is accepted.
module top_n_rssi_reply_ranker #(
  parameter int LIST_DEPTH = 8
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic cfg_wdata,
  nrr_in_if.sink  in_ch,
  nrr_out_if.source out_ch
);
  localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam logic [AW-1:0] LAST = AW'(LIST_DEPTH - 1);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CLEAR = 6'b000010,
    S_SCAN  = 6'b000100,
    S_SHIFT = 6'b001000,
    S_DUMP  = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t state;
  logic low_is_best;
  logic [7:0] offered_count;
  nrr_pkg::in_word_t cur;
  logic [AW-1:0] ptr;
  logic [AW:0] scan_cnt;
  logic [AW-1:0] pos;
  logic dup;
  logic worse0;
  logic [AW-1:0] dump_idx;
  logic dump_rd;
  logic [2:0] pend_status;

  logic we;
  logic [AW-1:0] waddr, raddr;
  nrr_pkg::entry_t wdata, rdata;
  logic [7:0] worst;

  nrr_mem #(.DEPTH(LIST_DEPTH), .AW(AW)) u_mem (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign worst = low_is_best ? 8'd255 : 8'd0;

  function automatic logic worse(input logic rev, input logic [7:0] a, input logic [7:0] b);
    worse = rev ? (a > b) : (a < b);
  endfunction

  logic [AW-1:0] rd_idx;
  logic rd_vld;
  assign rd_idx = scan_cnt[AW-1:0] - AW'(1);
  assign rd_vld = (state == S_SCAN) && (scan_cnt != '0) &&
                  (scan_cnt <= (AW+1)'(LIST_DEPTH));

  always_comb begin
    we = 1'b0;
    waddr = ptr;
    wdata = rdata;
    raddr = ptr;
    case (state)
      S_CLEAR: begin
        we = 1'b1;
        wdata = '0;
        wdata.rssi_upstream = worst;
        wdata.rssi_downstream = worst;
      end
      S_SCAN: raddr = scan_cnt[AW-1:0];
      S_SHIFT: begin
        raddr = ptr + AW'(1);
        if (ptr == pos) begin
          we = 1'b1;
          wdata = cur.e;
        end else begin
          we = dump_rd;
          waddr = ptr;
        end
      end
      S_DUMP: raddr = dump_idx;
      default: raddr = ptr;
    endcase
  end

  assign in_ch.ready = (state == S_IDLE) && !out_ch.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      low_is_best <= 1'b0;
      offered_count <= '0;
      ptr <= '0;
      out_ch.valid <= 1'b0;
      dump_rd <= 1'b0;
      scan_cnt <= '0;
      dump_idx <= '0;
      pend_status <= nrr_pkg::ST_INSERTED;
    end else begin
      if (cfg_we) begin
        low_is_best <= cfg_wdata;
      end
      if (out_ch.valid && out_ch.ready && !((state == S_DUMP) && dump_rd)) begin
        out_ch.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            cur <= in_ch.data;
            ptr <= '0;
            case (in_ch.data.operation)
              nrr_pkg::OP_CLEAR: begin
                offered_count <= '0;
                pend_status <= nrr_pkg::ST_CLEARED;
                state <= S_CLEAR;
              end
              nrr_pkg::OP_ADD: begin
                if (offered_count != nrr_pkg::COUNT_MAX) begin
                  offered_count <= offered_count + 8'd1;
                end
                scan_cnt <= '0;
                dup <= 1'b0;
                pos <= '0;
                state <= S_SCAN;
              end
              nrr_pkg::OP_DUMP: begin
                if (offered_count == '0) begin
                  out_ch.data.status <= nrr_pkg::ST_DUMP_EMPTY;
                  out_ch.data.reply_count <= '0;
                  out_ch.data.rank <= '0;
                  out_ch.data.e <= '0;
                  out_ch.data.last <= 1'b1;
                  out_ch.valid <= 1'b1;
                end else begin
                  dump_idx <= '0;
                  dump_rd <= 1'b0;
                  state <= S_DUMP;
                end
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_CLEAR: begin
          ptr <= ptr + AW'(1);
          if (ptr == LAST) begin
            if (pend_status == nrr_pkg::ST_CLEARED) begin
              out_ch.data.status <= nrr_pkg::ST_CLEARED;
              out_ch.data.reply_count <= '0;
              out_ch.data.rank <= '0;
              out_ch.data.e <= '0;
              out_ch.data.last <= 1'b1;
              out_ch.valid <= 1'b1;
              pend_status <= nrr_pkg::ST_INSERTED;
            end
            state <= S_IDLE;
          end
        end
        S_SCAN: begin
          scan_cnt <= scan_cnt + (AW+1)'(1);
          if (rd_vld) begin
            if ({rdata.gateway_id, rdata.modem_id} == {cur.e.gateway_id, cur.e.modem_id}) begin
              dup <= 1'b1;
            end
            if (rd_idx == '0) begin
              worse0 <= worse(low_is_best, cur.e.rssi_downstream, rdata.rssi_downstream);
            end else if (!worse(low_is_best, cur.e.rssi_downstream,
                                rdata.rssi_downstream) && (pos == rd_idx - AW'(1))) begin
              pos <= rd_idx;
            end
          end
          if (scan_cnt == (AW+1)'(LIST_DEPTH + 1)) begin
            out_ch.data.reply_count <= offered_count;
            out_ch.data.rank <= '0;
            out_ch.data.e <= '0;
            out_ch.data.last <= 1'b1;
            if (dup || worse0) begin
              out_ch.data.status <= dup ? nrr_pkg::ST_DUPLICATE : nrr_pkg::ST_DROPPED;
              out_ch.valid <= 1'b1;
              state <= S_IDLE;
            end else begin
              ptr <= '0;
              dump_rd <= 1'b0;
              state <= S_SHIFT;
            end
          end
        end
        S_SHIFT: begin
          if (ptr == pos) begin
            out_ch.data.status <= nrr_pkg::ST_INSERTED;
            out_ch.valid <= 1'b1;
            state <= S_IDLE;
          end else if (!dump_rd) begin
            dump_rd <= 1'b1;
          end else begin
            dump_rd <= 1'b0;
            ptr <= ptr + AW'(1);
          end
        end
        S_DUMP: begin
          if (!dump_rd) begin
            dump_rd <= 1'b1;
          end else if (!out_ch.valid || out_ch.ready) begin
            out_ch.data.status <= nrr_pkg::ST_DUMP_ENTRY;
            out_ch.data.reply_count <= offered_count;
            out_ch.data.rank <= 3'(dump_idx);
            out_ch.data.e <= rdata;
            out_ch.data.last <= (dump_idx == LAST);
            out_ch.valid <= 1'b1;
            dump_rd <= 1'b0;
            dump_idx <= dump_idx + AW'(1);
            if (dump_idx == LAST) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
module testbench;
  localparam int DEPTH = 8;
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk;
  logic rst;
  logic cfg_we;
  logic cfg_wdata;

  nrr_in_if in_ch();
  nrr_out_if out_ch();

  top_n_rssi_reply_ranker #(.LIST_DEPTH(DEPTH)) i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source)
  );

  // Predicted list contents, slot 0 holds the worst reply.
  nrr_pkg::entry_t ranked[DEPTH];
  logic [7:0] offered;
  logic reversed;

  nrr_pkg::in_word_t pending_words[$];
  nrr_pkg::out_word_t expected_words[$];

  int send_idle_pct;
  int recv_stall_pct;
  int hold_off_cycles;
  int errors;
  int accepted_in;
  int accepted_out;
  int idle_cycles;
  int dumps_seen;
  int inserts_seen;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic worse_than(logic [7:0] a, logic [7:0] b);
    return reversed ? (a > b) : (a < b);
  endfunction

  task automatic clear_ranking();
    nrr_pkg::entry_t blank;
    blank = '0;
    blank.rssi_upstream = reversed ? 8'hff : 8'h00;
    blank.rssi_downstream = reversed ? 8'hff : 8'h00;
    for (int i = 0; i < DEPTH; i++) ranked[i] = blank;
    offered = '0;
  endtask

  function automatic logic [2:0] rank_reply(nrr_pkg::entry_t e);
    int pos;
    if (offered != nrr_pkg::COUNT_MAX) offered++;
    for (int i = 0; i < DEPTH; i++) begin
      if ({ranked[i].gateway_id, ranked[i].modem_id} == {e.gateway_id, e.modem_id}) begin
        return nrr_pkg::ST_DUPLICATE;
      end
    end
    if (worse_than(e.rssi_downstream, ranked[0].rssi_downstream)) return nrr_pkg::ST_DROPPED;
    pos = 0;
    while (pos < DEPTH - 1 && !worse_than(e.rssi_downstream, ranked[pos + 1].rssi_downstream))
      pos++;
    for (int i = 0; i < pos; i++) ranked[i] = ranked[i + 1];
    ranked[pos] = e;
    return nrr_pkg::ST_INSERTED;
  endfunction

  task automatic predict_ranker(nrr_pkg::in_word_t w);
    nrr_pkg::out_word_t r;
    r = '0;
    r.last = 1'b1;
    case (w.operation)
      nrr_pkg::OP_CLEAR: begin
        clear_ranking();
        r.status = nrr_pkg::ST_CLEARED;
        expected_words.push_back(r);
      end
      nrr_pkg::OP_ADD: begin
        r.status = rank_reply(w.e);
        r.reply_count = offered;
        expected_words.push_back(r);
      end
      nrr_pkg::OP_DUMP: begin
        if (offered == 0) begin
          r.status = nrr_pkg::ST_DUMP_EMPTY;
          expected_words.push_back(r);
        end else begin
          for (int i = 0; i < DEPTH; i++) begin
            r.status = nrr_pkg::ST_DUMP_ENTRY;
            r.reply_count = offered;
            r.rank = 3'(i);
            r.e = ranked[i];
            r.last = (i == DEPTH - 1);
            expected_words.push_back(r);
          end
        end
      end
      default: ;
    endcase
  endtask

  // Driver.
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_ranker(in_ch.data);
        accepted_in++;
      end
      if ((!in_ch.valid || in_ch.ready) ) begin
        if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_ch.data <= pending_words.pop_front();
          in_ch.valid <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor and checker.
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        accepted_out++;
        if (out_ch.data.status == nrr_pkg::ST_DUMP_ENTRY) dumps_seen++;
        if (out_ch.data.status == nrr_pkg::ST_INSERTED) inserts_seen++;
        if (expected_words.size() == 0) begin
          errors++;
          $display("%0t: unexpected word %h", $time, out_ch.data);
        end else if (out_ch.data !== expected_words[0]) begin
          errors++;
          $display("%0t: mismatch expected %h actual %h", $time, expected_words[0],
                   out_ch.data);
          void'(expected_words.pop_front());
        end else begin
          void'(expected_words.pop_front());
        end
      end
      if (hold_off_cycles > 0) begin
        hold_off_cycles--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired after %0d cycles without a transfer.", idle_cycles);
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic nrr_pkg::in_word_t make_add(logic [47:0] gw, logic [7:0] modem,
                                                 logic [7:0] down);
    nrr_pkg::in_word_t w;
    w.operation = nrr_pkg::OP_ADD;
    w.e.gateway_id = gw;
    w.e.modem_id = modem;
    w.e.rssi_upstream = 8'($urandom);
    w.e.rssi_downstream = down;
    w.e.pong_epoch = $urandom;
    w.e.freq_offset = 16'($urandom);
    w.e.recv_time_us = $urandom;
    return w;
  endfunction

  function automatic nrr_pkg::in_word_t make_op(logic [1:0] op);
    nrr_pkg::in_word_t w;
    w = '0;
    w.e.gateway_id = {$urandom, $urandom};
    w.e.rssi_downstream = 8'($urandom);
    w.operation = op;
    return w;
  endfunction

  function automatic nrr_pkg::in_word_t random_word();
    int pick;
    logic [47:0] gw;
    pick = $urandom_range(99);
    if (pick < 5) return make_op(nrr_pkg::OP_CLEAR);
    if (pick < 15) return make_op(nrr_pkg::OP_DUMP);
    if (pick < 17) return make_op(2'd3);
    case ($urandom_range(3))
      0: gw = {$urandom, $urandom};
      1: gw = 48'($urandom_range(3));
      2: gw = 48'hffff_ffff_ffff;
      default: gw = {$urandom, $urandom} & 48'hffff_0000_00ff;
    endcase
    return make_add(gw, $urandom_range(3) == 0 ? 8'($urandom_range(2)) : 8'($urandom),
                    $urandom_range(3) == 0 ? 8'($urandom_range(1) * 255) :
                    8'($urandom_range(3)) == 0 ? 8'(120 + $urandom_range(4)) : 8'($urandom));
  endfunction

  task automatic wait_drained();
    while (pending_words.size() > 0 || in_ch.valid || expected_words.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_order(logic value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    reversed = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(int count, int idle_pct, int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < count; i++) pending_words.push_back(random_word());
    wait_drained();
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    reversed = 1'b0;
    errors = 0;
    accepted_in = 0;
    accepted_out = 0;
    idle_cycles = 0;
    dumps_seen = 0;
    inserts_seen = 0;
    hold_off_cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    clear_ranking();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed part: empty dump, zero key, extremes, ties, unused operation.
    pending_words.push_back(make_op(nrr_pkg::OP_DUMP));
    pending_words.push_back(make_add(48'h0, 8'h0, 8'd50));
    pending_words.push_back(make_op(nrr_pkg::OP_DUMP));
    pending_words.push_back(make_add(48'hffff_ffff_ffff, 8'hff, 8'd255));
    pending_words.push_back(make_add(48'h1, 8'h1, 8'd0));
    pending_words.push_back(make_add(48'h2, 8'h2, 8'd100));
    pending_words.push_back(make_add(48'h3, 8'h2, 8'd100));
    pending_words.push_back(make_add(48'h2, 8'h2, 8'd10));
    pending_words.push_back(make_op(2'd3));
    for (int i = 0; i < 6; i++)
      pending_words.push_back(make_add(48'h10 + 48'(i), 8'(i), 8'(200 - 20 * i)));
    pending_words.push_back(make_add(48'h20, 8'h0, 8'd1));
    pending_words.push_back(make_add(48'h21, 8'h0, 8'd101));
    pending_words.push_back(make_op(nrr_pkg::OP_DUMP));
    pending_words.push_back(make_op(nrr_pkg::OP_CLEAR));
    pending_words.push_back(make_op(nrr_pkg::OP_DUMP));
    wait_drained();

    write_order(1'b1);
    pending_words.push_back(make_op(nrr_pkg::OP_CLEAR));
    pending_words.push_back(make_add(48'h0, 8'h0, 8'd0));
    pending_words.push_back(make_add(48'h7, 8'h1, 8'd255));
    pending_words.push_back(make_add(48'h8, 8'h1, 8'd0));
    pending_words.push_back(make_op(nrr_pkg::OP_DUMP));
    wait_drained();
    run_phase(60, 0, 0);

    write_order(1'b0);
    pending_words.push_back(make_op(nrr_pkg::OP_CLEAR));
    run_phase(60, 80, 0);

    // Long receiver hold-off while the sender keeps offering words.
    hold_off_cycles = 300;
    run_phase(50, 0, 80);

    write_order(1'b1);
    pending_words.push_back(make_op(nrr_pkg::OP_CLEAR));
    run_phase(60, 34, 34);

    write_order(1'b0);
    run_phase(10, 0, 0);

    $display("Covered %0d input words and %0d result words (%0d inserts, %0d dump entries).",
             accepted_in, accepted_out, inserts_seen, dumps_seen);
    $display("Both ranking orders, duplicate and zero keys, ties, empty dumps, a long stall "
             , "and idle phases exercised.");
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

>>> filelist.f
src/nrr_pkg.sv
src/nrr_if.sv
src/nrr_mem.sv
src/top_n_rssi_reply_ranker.sv
bench/testbench.sv
